[rtl/core/idv_pkg.sv]
// Shared types, constants and reserved-word tables for the identifier name validator.
`default_nettype none

package idv_pkg;

  localparam int unsigned DEF_KEYWORD_COUNT = 19;
  localparam int unsigned MAX_KEYWORD_LEN   = 13;
  localparam int unsigned POS_W             = 4;
  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned KW_INDEX_W        = 5;
  localparam int unsigned KW_TEXT_W         = 128;

  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F;

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_BAD_FIRST = 3'd1,
    REASON_DOT_DIGIT = 3'd2,
    REASON_BAD_LATER = 3'd3,
    REASON_RESERVED  = 3'd4
  } reason_e;

  typedef struct packed {
    logic is_zero;
    logic is_letter;
    logic is_digit;
    logic is_dot;
    logic is_under;
  } char_class_t;

  // Reserved word text, right-justified: the last character sits in the low byte.
  function automatic logic [KW_TEXT_W-1:0] kw_text(input logic [KW_INDEX_W-1:0] k);
    case (k)
      5'd0:    return KW_TEXT_W'("NULL");
      5'd1:    return KW_TEXT_W'("NA");
      5'd2:    return KW_TEXT_W'("TRUE");
      5'd3:    return KW_TEXT_W'("FALSE");
      5'd4:    return KW_TEXT_W'("Inf");
      5'd5:    return KW_TEXT_W'("NaN");
      5'd6:    return KW_TEXT_W'({"NA", "_integer_"});
      5'd7:    return KW_TEXT_W'({"NA", "_real_"});
      5'd8:    return KW_TEXT_W'({"NA", "_character_"});
      5'd9:    return KW_TEXT_W'({"NA", "_complex_"});
      5'd10:   return KW_TEXT_W'("function");
      5'd11:   return KW_TEXT_W'("while");
      5'd12:   return KW_TEXT_W'("repeat");
      5'd13:   return KW_TEXT_W'("for");
      5'd14:   return KW_TEXT_W'("if");
      5'd15:   return KW_TEXT_W'("in");
      5'd16:   return KW_TEXT_W'("else");
      5'd17:   return KW_TEXT_W'("next");
      5'd18:   return KW_TEXT_W'("break");
      default: return '0;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] kw_len(input logic [KW_INDEX_W-1:0] k);
    case (k)
      5'd0:    return 4'd4;
      5'd1:    return 4'd2;
      5'd2:    return 4'd4;
      5'd3:    return 4'd5;
      5'd4:    return 4'd3;
      5'd5:    return 4'd3;
      5'd6:    return 4'd11;
      5'd7:    return 4'd8;
      5'd8:    return 4'd13;
      5'd9:    return 4'd11;
      5'd10:   return 4'd8;
      5'd11:   return 4'd5;
      5'd12:   return 4'd6;
      5'd13:   return 4'd3;
      5'd14:   return 4'd2;
      5'd15:   return 4'd2;
      5'd16:   return 4'd4;
      5'd17:   return 4'd4;
      5'd18:   return 4'd5;
      default: return 4'd0;
    endcase
  endfunction

  // Character of word k at position pos; only meaningful when pos is below the length.
  function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_INDEX_W-1:0] k,
                                                input logic [POS_W-1:0] pos);
    logic [KW_TEXT_W-1:0] text;
    logic [POS_W-1:0]     idx;
    text = kw_text(k);
    idx  = kw_len(k) - pos - POS_W'(1);
    return text[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

[rtl/core/idv_char_class.sv]
// ASCII character classification of one name byte.
`default_nettype none

module idv_char_class (
  input  logic [idv_pkg::CHAR_W-1:0] char_byte_i,
  output idv_pkg::char_class_t       cls_o
);

  always_comb begin
    cls_o.is_zero   = (char_byte_i == '0);
    cls_o.is_letter = ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A)) ||
                      ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A));
    cls_o.is_digit  = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
    cls_o.is_dot    = (char_byte_i == idv_pkg::CHAR_DOT);
    cls_o.is_under  = (char_byte_i == idv_pkg::CHAR_UNDER);
  end

endmodule

`default_nettype wire

[rtl/core/idv_kw_match.sv]
// Reserved-word candidate mask narrowing and final full-length match.
`default_nettype none

module idv_kw_match #(
  parameter int unsigned KEYWORD_COUNT = idv_pkg::DEF_KEYWORD_COUNT
) (
  input  logic [idv_pkg::CHAR_W-1:0] char_byte_i,
  input  logic [idv_pkg::POS_W-1:0]  position_i,
  input  logic [KEYWORD_COUNT-1:0]   cand_i,
  output logic [KEYWORD_COUNT-1:0]   cand_next_o,
  output logic                       reserved_hit_o
);

  localparam logic [idv_pkg::POS_W-1:0] MaxLen = idv_pkg::POS_W'(idv_pkg::MAX_KEYWORD_LEN);

  logic [KEYWORD_COUNT-1:0] full_match;

  for (genvar k = 0; k < KEYWORD_COUNT; k++) begin : g_kw
    localparam logic [idv_pkg::KW_INDEX_W-1:0] KwIdx = idv_pkg::KW_INDEX_W'(k);

    // A word stays a candidate only while every byte so far has matched it.
    assign cand_next_o[k] = cand_i[k] && (position_i < MaxLen) &&
                            (position_i < idv_pkg::kw_len(KwIdx)) &&
                            (idv_pkg::kw_char(KwIdx, position_i) == char_byte_i);

    assign full_match[k]  = cand_i[k] && (idv_pkg::kw_len(KwIdx) == position_i) &&
                            (position_i <= MaxLen);
  end

  assign reserved_hit_o = |full_match;

endmodule

`default_nettype wire

[rtl/core/identifier_name_validator_core.sv]
// Identifier name validator: input register, per-byte update logic and result register.
// Order: an accepted byte updates the name state as it leaves the input register; a zero
// byte writes its result into the result register. Throughput: one byte per cycle, set
// by the single input register stage, while no zero byte waits on a full, stalled result
// register. Reset: asynchronous active low; clears the name state, the keyword mask to
// all ones and both valid flags.
`default_nettype none

module identifier_name_validator_core #(
  parameter int unsigned KEYWORD_COUNT = idv_pkg::DEF_KEYWORD_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [idv_pkg::CHAR_W-1:0] char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       name_ok_o,
  output logic [2:0]                 reason_o
);

  localparam logic [idv_pkg::POS_W-1:0] PosMax = '1;

  // Input register
  logic                       s1_valid_q, s1_valid_d;
  logic [idv_pkg::CHAR_W-1:0] s1_byte_q;

  // Name state
  logic [idv_pkg::POS_W-1:0] pos_q, pos_d;
  idv_pkg::reason_e          err_q, err_d;
  logic                      lead_dot_q, lead_dot_d;
  logic [KEYWORD_COUNT-1:0]  cand_q, cand_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic             name_ok_q;
  idv_pkg::reason_e reason_q;

  idv_pkg::char_class_t     cls;
  logic [KEYWORD_COUNT-1:0] cand_next;
  logic                     reserved_hit;
  logic                     s1_move;
  logic                     in_take;
  idv_pkg::reason_e         result_reason;

  idv_char_class u_char_class (
    .char_byte_i (s1_byte_q),
    .cls_o       (cls)
  );

  idv_kw_match #(
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_kw_match (
    .char_byte_i    (s1_byte_q),
    .position_i     (pos_q),
    .cand_i         (cand_q),
    .cand_next_o    (cand_next),
    .reserved_hit_o (reserved_hit)
  );

  // Only a terminating byte needs room in the result register.
  assign s1_move    = s1_valid_q && (!cls.is_zero || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    result_reason = err_q;
    if (err_q == idv_pkg::REASON_OK) begin
      if (pos_q == '0) begin
        result_reason = idv_pkg::REASON_BAD_FIRST;
      end else if (reserved_hit) begin
        result_reason = idv_pkg::REASON_RESERVED;
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    err_d       = err_q;
    lead_dot_d  = lead_dot_q;
    cand_d      = cand_q;

    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (s1_move) begin
      if (cls.is_zero) begin
        out_valid_d = 1'b1;
        pos_d       = '0;
        err_d       = idv_pkg::REASON_OK;
        lead_dot_d  = 1'b0;
        cand_d      = '1;
      end else begin
        // The first error found is kept until the name ends.
        if (err_q == idv_pkg::REASON_OK) begin
          if (pos_q == '0) begin
            if (cls.is_dot) begin
              lead_dot_d = 1'b1;
            end else if (!cls.is_letter) begin
              err_d = idv_pkg::REASON_BAD_FIRST;
            end
          end else if ((pos_q == idv_pkg::POS_W'(1)) && lead_dot_q && cls.is_digit) begin
            err_d = idv_pkg::REASON_DOT_DIGIT;
          end else if (!(cls.is_letter || cls.is_digit || cls.is_dot || cls.is_under)) begin
            err_d = idv_pkg::REASON_BAD_LATER;
          end
        end
        cand_d = cand_next;
        if (pos_q != PosMax) begin
          pos_d = pos_q + idv_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      err_q       <= idv_pkg::REASON_OK;
      lead_dot_q  <= 1'b0;
      cand_q      <= '1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      err_q       <= err_d;
      lead_dot_q  <= lead_dot_d;
      cand_q      <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= char_byte_i;
    end
    if (s1_move && cls.is_zero) begin
      name_ok_q <= (result_reason == idv_pkg::REASON_OK);
      reason_q  <= result_reason;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_ok_o   = name_ok_q;
  assign reason_o    = reason_q;

endmodule

`default_nettype wire
